FILE: rtl/mnnp_pkg.sv
// Shared widths, configuration register indexes, reset values and constants for the nearest-neighbour precision block.
package mnnp_pkg;

  // Field and register widths.
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PCFG_W   = 7;
  localparam int unsigned DCFG_W   = 5;
  localparam int unsigned BCFG_W   = 5;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned WIDE_W   = 64;
  localparam int unsigned NEAR_W   = 48;
  localparam int unsigned DSTEP_W  = 7;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DIM_COUNT   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BASIS_COUNT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_INIT_PREC   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [PCFG_W-1:0] POINT_COUNT_RST = 7'd64;
  localparam logic [DCFG_W-1:0] DIM_COUNT_RST   = 5'd16;
  localparam logic [BCFG_W-1:0] BASIS_COUNT_RST = 5'd16;
  localparam logic [DATA_W-1:0] INIT_PREC_RST   = 32'hFFFF_FFFF;

  // Dividend for the precision, 2.0 in Q16.16 scaled by another 2^16.
  localparam logic [WIDE_W-1:0] TWO_SCALED = 64'h0000_0002_0000_0000;

endpackage

FILE: rtl/mean_nearest_neighbour_precision.sv
// Nearest-neighbour precision estimator: point projection, distance search and division.
// Weight word: one restoring divider step a cycle splits the position.
// Activation word: one shared multiplier; each coordinate is read, multiplied and written back.
// Last word adds a distance search over all ordered pairs of distinct points, the mean division, a
// precision division if the mean is nonzero and a clearing sweep. One word at a time; ready only when idle.
// Reset: asynchronous, active low; the point memory is swept to zero.
module mean_nearest_neighbour_precision #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned MAX_DIMS   = 16,
  parameter int unsigned MAX_BASIS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mnnp_pkg::CIDX_W-1:0]       cfg_idx_i,
  input  logic [mnnp_pkg::DATA_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic signed [mnnp_pkg::DATA_W-1:0] value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mnnp_pkg::DATA_W-1:0]       precision_o,
  output logic [mnnp_pkg::DATA_W-1:0]       mean_distance_o
);

  localparam int unsigned PDEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int unsigned WDEPTH  = MAX_BASIS * MAX_DIMS;
  localparam int unsigned PADDR_W = $clog2(PDEPTH);
  localparam int unsigned WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int unsigned PT_W    = $clog2(MAX_POINTS);
  localparam int unsigned PCNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DCNT_W  = $clog2(MAX_DIMS + 1);
  localparam int unsigned BAS_W   = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int unsigned BCNT_W  = $clog2(MAX_BASIS + 1);
  localparam int unsigned ACT_LIMIT = MAX_POINTS * MAX_BASIS;
  localparam int unsigned APOS_W  = $clog2(ACT_LIMIT + 1);
  localparam int unsigned WPOS_W  = $clog2(WDEPTH + 1);
  localparam int unsigned POS_W   = (APOS_W > WPOS_W) ? APOS_W : WPOS_W;
  localparam int unsigned DW      = mnnp_pkg::DATA_W;
  localparam int unsigned XW      = mnnp_pkg::WIDE_W;
  localparam int unsigned NW      = mnnp_pkg::NEAR_W;
  localparam int unsigned SW      = mnnp_pkg::DSTEP_W;

  // Sequencer states.
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_POSDIV   = 4'd2;
  localparam logic [3:0] S_ACT_RD   = 4'd3;
  localparam logic [3:0] S_ACT_MUL  = 4'd4;
  localparam logic [3:0] S_ACT_WR   = 4'd5;
  localparam logic [3:0] S_DIST_RD  = 4'd6;
  localparam logic [3:0] S_DIST_MUL = 4'd7;
  localparam logic [3:0] S_DIST_ACC = 4'd8;
  localparam logic [3:0] S_PAIR_END = 4'd9;
  localparam logic [3:0] S_MEAN_DIV = 4'd10;
  localparam logic [3:0] S_PREC_DIV = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state_q;

  // Configuration registers.
  logic [mnnp_pkg::PCFG_W-1:0] pcfg_q;
  logic [mnnp_pkg::DCFG_W-1:0] dcfg_q;
  logic [mnnp_pkg::BCFG_W-1:0] bcfg_q;
  logic [DW-1:0]               init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcfg_q <= mnnp_pkg::POINT_COUNT_RST;
      dcfg_q <= mnnp_pkg::DIM_COUNT_RST;
      bcfg_q <= mnnp_pkg::BASIS_COUNT_RST;
      init_q <= mnnp_pkg::INIT_PREC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mnnp_pkg::REG_POINT_COUNT: pcfg_q <= cfg_data_i[mnnp_pkg::PCFG_W-1:0];
        mnnp_pkg::REG_DIM_COUNT:   dcfg_q <= cfg_data_i[mnnp_pkg::DCFG_W-1:0];
        mnnp_pkg::REG_BASIS_COUNT: bcfg_q <= cfg_data_i[mnnp_pkg::BCFG_W-1:0];
        mnnp_pkg::REG_INIT_PREC:   init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective counts, clamped into their ranges.
  logic [PCNT_W-1:0] p_eff;
  logic [DCNT_W-1:0] d_eff;
  logic [BCNT_W-1:0] b_eff;

  always_comb begin
    if (32'(pcfg_q) < 32'd2) p_eff = PCNT_W'(2);
    else if (32'(pcfg_q) > 32'(MAX_POINTS)) p_eff = PCNT_W'(MAX_POINTS);
    else p_eff = PCNT_W'(pcfg_q);
    if (dcfg_q == '0) d_eff = DCNT_W'(1);
    else if (32'(dcfg_q) > 32'(MAX_DIMS)) d_eff = DCNT_W'(MAX_DIMS);
    else d_eff = DCNT_W'(dcfg_q);
    if (bcfg_q == '0) b_eff = BCNT_W'(1);
    else if (32'(bcfg_q) > 32'(MAX_BASIS)) b_eff = BCNT_W'(MAX_BASIS);
    else b_eff = BCNT_W'(bcfg_q);
  end

  // Datapath registers.
  logic [DW-1:0]     a_q;
  logic              mode_q;
  logic              last_q;
  logic [WPOS_W-1:0] wpos_q;
  logic [APOS_W-1:0] apos_q;
  logic [PT_W-1:0]   ri_q;
  logic [PT_W:0]     j_q;
  logic [BAS_W-1:0]  col_q;
  logic [DIM_W-1:0]  d_q;
  logic [XW-1:0]     mul_q;
  logic [XW-1:0]     acc_q;
  logic [NW-1:0]     nn_q;
  logic [XW-1:0]     total_q;
  logic [XW-1:0]     mean_q;
  logic [PADDR_W-1:0] clr_q;
  logic              out_valid_q;
  logic [DW-1:0]     prec_out_q;
  logic [DW-1:0]     mean_out_q;

  // Shared restoring divider, one quotient bit a cycle.
  logic [XW-1:0] div_num_q;
  logic [XW-1:0] div_rem_q;
  logic [XW-1:0] div_den_q;
  logic [SW-1:0] div_cnt_q;
  logic [XW:0]   rem_sh;
  logic [XW:0]   rem_sub;
  logic          div_ge;

  always_comb begin
    rem_sh  = {div_rem_q, div_num_q[XW-1]};
    rem_sub = rem_sh - {1'b0, div_den_q};
    div_ge  = (rem_sh >= {1'b0, div_den_q});
  end

  // Memories and their addresses.
  logic [DW-1:0] pmem [PDEPTH];
  logic [DW-1:0] wmem [WDEPTH];
  logic [DW-1:0] pa_rd_q;
  logic [DW-1:0] pb_rd_q;
  logic [DW-1:0] w_rd_q;
  logic [PADDR_W-1:0] pa_addr;
  logic [PADDR_W-1:0] pb_addr;
  logic [PADDR_W-1:0] pw_addr;
  logic [DW-1:0]      pw_data;
  logic               pw_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WADDR_W-1:0] ww_addr;
  logic               ww_en;

  assign pa_addr = PADDR_W'(PADDR_W'(ri_q) * PADDR_W'(MAX_DIMS) + PADDR_W'(d_q));
  assign pb_addr = PADDR_W'(PADDR_W'(j_q[PT_W-1:0]) * PADDR_W'(MAX_DIMS) + PADDR_W'(d_q));
  assign wr_addr = WADDR_W'(WADDR_W'(col_q) * WADDR_W'(MAX_DIMS) + WADDR_W'(d_q));
  assign ww_addr = WADDR_W'(WADDR_W'(div_num_q) * WADDR_W'(MAX_DIMS) + WADDR_W'(div_rem_q));
  assign ww_en   = (state_q == S_POSDIV) && (div_cnt_q == '0) && !mode_q
                   && (div_num_q < XW'(MAX_BASIS));

  always_ff @(posedge clk_i) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    pa_rd_q <= pmem[pa_addr];
    pb_rd_q <= pmem[pb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ww_en) wmem[ww_addr] <= a_q;
    w_rd_q <= wmem[wr_addr];
  end

  // Shared multiplier operands: activation times weight, or squared distance.
  logic signed [DW:0]   diff;
  logic [DW-1:0]        mag;
  logic signed [DW:0]   mul_a;
  logic signed [DW:0]   mul_b;
  logic signed [2*DW+1:0] prod;

  always_comb begin
    diff = $signed({pa_rd_q[DW-1], pa_rd_q}) - $signed({pb_rd_q[DW-1], pb_rd_q});
    mag  = diff[DW] ? DW'(-diff) : DW'(diff);
    if (state_q == S_ACT_MUL) begin
      mul_a = $signed({a_q[DW-1], a_q});
      mul_b = $signed({w_rd_q[DW-1], w_rd_q});
    end else begin
      mul_a = $signed({1'b0, mag});
      mul_b = $signed({1'b0, mag});
    end
    prod = mul_a * mul_b;
  end

  // Coordinate update with floor to Q16.16 and saturation to 32 bits.
  logic signed [XW-1:0] term;
  logic signed [XW-1:0] coord_sum;
  logic [DW-1:0]        coord_sat;

  always_comb begin
    term      = $signed(mul_q) >>> mnnp_pkg::FRAC_W;
    coord_sum = $signed(XW'($signed(pa_rd_q))) + term;
    if (coord_sum > $signed(XW'(32'sh7FFF_FFFF))) coord_sat = 32'h7FFF_FFFF;
    else if (coord_sum < -$signed(XW'(33'sh0_8000_0000))) coord_sat = 32'h8000_0000;
    else coord_sat = coord_sum[DW-1:0];
  end

  // Point memory write port: clearing sweep or coordinate update.
  always_comb begin
    pw_en   = (state_q == S_CLEAR) || (state_q == S_ACT_WR);
    pw_addr = (state_q == S_CLEAR) ? clr_q : pa_addr;
    pw_data = (state_q == S_CLEAR) ? '0 : coord_sat;
  end

  // Distance accumulation and pair bookkeeping.
  logic [XW:0]     acc_sum;
  logic [XW-1:0]   acc_sat;
  logic [NW-1:0]   acc_sh;
  logic [NW-1:0]   nn_new;
  logic [PT_W:0]   j_inc;
  logic [PT_W:0]   j_nxt;
  logic            d_end;
  logic            j_end;
  logic            i_end;

  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, mul_q};
    acc_sat = acc_sum[XW] ? '1 : acc_sum[XW-1:0];
    acc_sh  = NW'(acc_q >> mnnp_pkg::FRAC_W);
    nn_new  = (acc_sh < nn_q) ? acc_sh : nn_q;
    j_inc   = j_q + (PT_W+1)'(1);
    j_nxt   = (j_inc == (PT_W+1)'(ri_q)) ? j_q + (PT_W+1)'(2) : j_inc;
    d_end   = ((DCNT_W'(d_q) + DCNT_W'(1)) == d_eff);
    j_end   = (32'(j_nxt) >= 32'(p_eff));
    i_end   = ((32'(ri_q) + 32'd1) == 32'(p_eff));
  end

  // Final result formatting.
  logic [DW-1:0] prec_sat;
  logic [DW-1:0] prec_min;
  logic [DW-1:0] mean_sat;

  always_comb begin
    prec_sat = (|div_num_q[XW-1:DW]) ? '1 : div_num_q[DW-1:0];
    prec_min = (init_q < prec_sat) ? init_q : prec_sat;
    mean_sat = (|mean_q[XW-1:DW]) ? '1 : mean_q[DW-1:0];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      a_q         <= '0;
      mode_q      <= 1'b0;
      last_q      <= 1'b0;
      wpos_q      <= '0;
      apos_q      <= '0;
      ri_q        <= '0;
      j_q         <= '0;
      col_q       <= '0;
      d_q         <= '0;
      mul_q       <= '0;
      acc_q       <= '0;
      nn_q        <= '1;
      total_q     <= '0;
      mean_q      <= '0;
      div_num_q   <= '0;
      div_rem_q   <= '0;
      div_den_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      prec_out_q  <= '0;
      mean_out_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      // Divider step in any dividing state.
      if ((state_q == S_POSDIV || state_q == S_MEAN_DIV || state_q == S_PREC_DIV)
          && div_cnt_q != '0) begin
        div_rem_q <= rem_sub[XW-1:0] & {XW{div_ge}} | rem_sh[XW-1:0] & {XW{!div_ge}};
        div_num_q <= {div_num_q[XW-2:0], div_ge};
        div_cnt_q <= div_cnt_q - SW'(1);
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PADDR_W'(1);
          if (clr_q == PADDR_W'(PDEPTH - 1)) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            a_q       <= value_i;
            mode_q    <= mode_i;
            last_q    <= last_i;
            div_rem_q <= '0;
            div_cnt_q <= SW'(POS_W);
            if (mode_i) begin
              div_num_q <= {POS_W'(apos_q), (XW-POS_W)'(0)};
              div_den_q <= XW'(b_eff);
            end else begin
              div_num_q <= {POS_W'(wpos_q), (XW-POS_W)'(0)};
              div_den_q <= XW'(d_eff);
            end
            state_q <= S_POSDIV;
          end
        end

        S_POSDIV: begin
          if (div_cnt_q == '0) begin
            if (!mode_q) begin
              if (32'(wpos_q) < 32'(WDEPTH)) wpos_q <= wpos_q + WPOS_W'(1);
              state_q <= S_DIST_RD;
            end else begin
              if (32'(apos_q) < 32'(ACT_LIMIT)) apos_q <= apos_q + APOS_W'(1);
              state_q <= S_DIST_RD;
            end
            if (mode_q && div_num_q < XW'(p_eff)) begin
              ri_q    <= PT_W'(div_num_q);
              col_q   <= BAS_W'(div_rem_q);
              d_q     <= '0;
              state_q <= S_ACT_RD;
            end else if (last_q) begin
              ri_q    <= '0;
              j_q     <= (PT_W+1)'(1);
              d_q     <= '0;
              acc_q   <= '0;
              state_q <= S_DIST_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        S_ACT_RD: state_q <= S_ACT_MUL;

        S_ACT_MUL: begin
          mul_q   <= prod[XW-1:0];
          state_q <= S_ACT_WR;
        end

        S_ACT_WR: begin
          d_q <= d_q + DIM_W'(1);
          if (d_end) begin
            d_q <= '0;
            if (last_q) begin
              ri_q    <= '0;
              j_q     <= (PT_W+1)'(1);
              acc_q   <= '0;
              state_q <= S_DIST_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_ACT_RD;
          end
        end

        S_DIST_RD: state_q <= S_DIST_MUL;

        S_DIST_MUL: begin
          mul_q   <= prod[XW-1:0];
          state_q <= S_DIST_ACC;
        end

        S_DIST_ACC: begin
          acc_q <= acc_sat;
          d_q   <= d_q + DIM_W'(1);
          if (d_end) begin
            d_q     <= '0;
            state_q <= S_PAIR_END;
          end else begin
            state_q <= S_DIST_RD;
          end
        end

        S_PAIR_END: begin
          acc_q   <= '0;
          nn_q    <= nn_new;
          j_q     <= j_nxt;
          state_q <= S_DIST_RD;
          if (j_end) begin
            total_q <= total_q + XW'(nn_new);
            nn_q    <= '1;
            ri_q    <= ri_q + PT_W'(1);
            j_q     <= '0;
            if (i_end) begin
              div_num_q <= total_q + XW'(nn_new);
              div_rem_q <= '0;
              div_den_q <= XW'(p_eff);
              div_cnt_q <= SW'(XW);
              state_q   <= S_MEAN_DIV;
            end
          end
        end

        S_MEAN_DIV: begin
          if (div_cnt_q == '0) begin
            mean_q <= div_num_q;
            if (div_num_q == '0) begin
              state_q <= S_DONE;
            end else begin
              div_num_q <= mnnp_pkg::TWO_SCALED;
              div_rem_q <= '0;
              div_den_q <= div_num_q;
              div_cnt_q <= SW'(XW);
              state_q   <= S_PREC_DIV;
            end
          end
        end

        S_PREC_DIV: begin
          if (div_cnt_q == '0) state_q <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            mean_out_q  <= mean_sat;
            prec_out_q  <= (mean_q == '0) ? init_q : prec_min;
            wpos_q      <= '0;
            apos_q      <= '0;
            total_q     <= '0;
            ri_q        <= '0;
            j_q         <= '0;
            nn_q        <= '1;
            clr_q       <= '0;
            state_q     <= S_CLEAR;
          end
        end

        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign precision_o     = prec_out_q;
  assign mean_distance_o = mean_out_q;

endmodule
